// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/lrde_pkg.sv =====
package lrde_pkg;

  // field widths
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SENSORS = 8;
  localparam int THR_BITS    = 10;
  localparam int DIR_BITS    = 10;
  localparam int DIST_BITS   = 5;
  localparam int RUN_BITS    = 4;

  // cordic datapath widths and constants
  localparam int XW        = 38;
  localparam int ZW        = 32;
  localparam int DEG_BITS  = 9;
  localparam int STEP_BITS = 4;
  // two rotations per step, thirty rotations in all
  localparam int CORDIC_STEPS = 15;

  localparam logic signed [XW-1:0] ONE_Q32       = 38'sd4294967296;
  localparam logic signed [XW-1:0] HALF_ROOT_Q32 = 38'sd3037000500;
  localparam logic [41:0]          OFFSET_Q32    = 42'd96636764160;
  localparam logic [ZW-1:0]        ANGLE_HALF    = 32'h8000_0000;
  localparam logic [DEG_BITS-1:0]  DEG_FULL      = 9'd360;

  localparam logic [THR_BITS-1:0]  THR_RESET = 10'd30;
  localparam logic [DIR_BITS-1:0]  DIR_NONE  = 10'h3FF;
  localparam logic [DIST_BITS-1:0] DIST_NONE = 5'h1F;

  // register index of the threshold
  localparam logic REG_THRESHOLD = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic                 accept;
    logic                 init;
    logic                 iter;
    logic [STEP_BITS-1:0] step;
    logic                 final_calc;
    logic                 load;
  } lrde_cmd_t;

  // cordic vector and angle
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ZW-1:0]        z;
  } lrde_rot_t;

  // arctangent of 2^-i as a binary angle, 2^32 is a full turn
  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000028;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000002;
      5'd29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // direction reported when only one sensor detects
  function automatic logic [DIR_BITS-1:0] single_dir(input logic [2:0] k);
    logic [DIR_BITS-1:0] d;
    case (k)
      3'd0:    d = 10'd46;
      3'd1:    d = 10'd91;
      3'd2:    d = 10'd136;
      3'd3:    d = 10'd181;
      3'd4:    d = 10'd226;
      3'd5:    d = 10'd271;
      3'd6:    d = 10'd316;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

  // direction for a sum that lies exactly between sensors j and j+1
  function automatic logic [DIR_BITS-1:0] tie_dir(input logic [2:0] j);
    logic [DIR_BITS-1:0] d;
    case (j)
      3'd0:    d = 10'd45;
      3'd1:    d = 10'd90;
      3'd2:    d = 10'd135;
      3'd3:    d = 10'd180;
      3'd4:    d = 10'd225;
      3'd5:    d = 10'd270;
      3'd6:    d = 10'd315;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/lrde_ctrl.sv =====
module lrde_ctrl import lrde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lrde_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ITER  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);

  logic [2:0]           state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  // output register can take a result when empty or draining this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        step_d     = '0;
        state_d    = S_ITER;
      end
      S_ITER: begin
        cmd_o.iter = 1'b1;
        cmd_o.step = step_q;
        if (step_q == LAST_STEP) begin
          state_d = S_FINAL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_FINAL: begin
        cmd_o.final_calc = 1'b1;
        state_d          = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result beat valid flag
  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/lrde_dp.sv =====
module lrde_dp import lrde_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lrde_cmd_t                           cmd_i,
  input  logic [NUM_SENSORS*SAMPLE_BITS-1:0]  samples_i,
  input  logic [THR_BITS-1:0]                 thr_i,
  output logic [DIR_BITS-1:0]                 dir_o,
  output logic [DIST_BITS-1:0]                dist_o
);

  logic [NUM_SENSORS-1:0] det_q;
  logic [NUM_SENSORS-1:0] det_now;
  lrde_rot_t              rot_q, rot_d, rot_init, rot_mid, rot_end;
  logic                   mode_q, mode_d;
  logic [RUN_BITS-1:0]    run0_q, run0_d, run1_q, run1_d;
  logic [DEG_BITS-1:0]    deg_q;
  logic [DEG_BITS-1:0]    deg_mod;
  logic [41:0]            deg_raw;
  logic [DIR_BITS-1:0]    prev_q;
  logic [DIR_BITS-1:0]    dir_q, dir_d;
  logic [DIST_BITS-1:0]   dist_q, dist_d;
  logic signed [2:0]      xa, xb, ya, yb;
  logic signed [XW-1:0]   x0, y0;
  logic                   zero_sum, one_hot, cnt_two;
  logic [3:0]             det_cnt;
  logic [2:0]             first_k;
  logic                   tie_hit;
  logic [2:0]             tie_j;
  logic [RUN_BITS-1:0]    run_min;

  function automatic logic signed [2:0] ext(input logic b);
    return {2'b00, b};
  endfunction

  // a * 2^32 for a in -1..1
  function automatic logic signed [XW-1:0] a_term(input logic signed [2:0] a);
    logic signed [XW-1:0] t;
    case (a)
      3'b001:  t = ONE_Q32;
      3'b111:  t = -ONE_Q32;
      default: t = '0;
    endcase
    return t;
  endfunction

  // b * sqrt(2)/2 * 2^32 for b in -2..2
  function automatic logic signed [XW-1:0] b_term(input logic signed [2:0] b);
    logic signed [XW-1:0] t;
    case (b)
      3'b001:  t = HALF_ROOT_Q32;
      3'b010:  t = HALF_ROOT_Q32 <<< 1;
      3'b111:  t = -HALF_ROOT_Q32;
      3'b110:  t = -(HALF_ROOT_Q32 <<< 1);
      default: t = '0;
    endcase
    return t;
  endfunction

  // shift that rounds toward zero
  function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                  input logic [4:0] s);
    logic signed [XW-1:0] r;
    if (v[XW-1]) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

  // one vectoring rotation
  function automatic lrde_rot_t rot_step(input lrde_rot_t r, input logic [4:0] i);
    lrde_rot_t            o;
    logic signed [XW-1:0] dx, dy;
    dx = r.x >>> i;
    dy = shr_tz(r.y, i);
    if (!r.y[XW-1] && (r.y != '0)) begin
      o.x = r.x + dy;
      o.y = r.y - dx;
      o.z = r.z + atan_lut(i);
    end else begin
      o.x = r.x - dy;
      o.y = r.y + dx;
      o.z = r.z - atan_lut(i);
    end
    return o;
  endfunction

  // threshold compare at the input beat
  always_comb begin
    for (int k = 0; k < NUM_SENSORS; k++) begin
      det_now[k] = samples_i[k*SAMPLE_BITS +: SAMPLE_BITS] <= thr_i;
    end
  end

  // vector sum as a + b*r per axis
  assign xa = ext(det_q[0]) - ext(det_q[4]);
  assign xb = ext(det_q[1]) - ext(det_q[3]) - ext(det_q[5]) + ext(det_q[7]);
  assign ya = ext(det_q[2]) - ext(det_q[6]);
  assign yb = ext(det_q[1]) + ext(det_q[3]) - ext(det_q[5]) - ext(det_q[7]);
  assign zero_sum = (xa == '0) && (xb == '0) && (ya == '0) && (yb == '0);

  // detection count and lowest detecting sensor
  always_comb begin
    det_cnt = '0;
    first_k = '0;
    for (int k = NUM_SENSORS - 1; k >= 0; k--) begin
      det_cnt = det_cnt + 4'(det_q[k]);
      if (det_q[k]) begin
        first_k = 3'(k);
      end
    end
  end
  assign one_hot = (det_cnt == 4'd1);
  assign cnt_two = (det_cnt == 4'd2);

  // exact ties: perpendicular part zero and parallel part positive
  always_comb begin
    logic signed [2:0] e1, e2, pa, pb;
    tie_hit = 1'b0;
    tie_j   = '0;
    for (int j = NUM_SENSORS - 1; j >= 0; j--) begin
      e1 = ext(det_q[3'(j + 1)]) + ext(det_q[3'(j + 4)])
         - ext(det_q[3'(j)]) - ext(det_q[3'(j + 5)]);
      e2 = ext(det_q[3'(j + 2)]) + ext(det_q[3'(j + 3)])
         - ext(det_q[3'(j + 7)]) - ext(det_q[3'(j + 6)]);
      pa = ext(det_q[3'(j + 1)]) + ext(det_q[3'(j)])
         - ext(det_q[3'(j + 4)]) - ext(det_q[3'(j + 5)]);
      pb = ext(det_q[3'(j + 2)]) + ext(det_q[3'(j + 7)])
         - ext(det_q[3'(j + 3)]) - ext(det_q[3'(j + 6)]);
      if ((e1 == '0) && (e2 == '0) &&
          ((pa > 3'sd0) || ((pa == '0) && (pb > 3'sd0)))) begin
        tie_hit = 1'b1;
        tie_j   = 3'(j);
      end
    end
  end

  // starting vector, turned by a half circle into the right half plane
  always_comb begin
    x0 = a_term(xa) + b_term(xb);
    y0 = a_term(ya) + b_term(yb);
    if (x0[XW-1]) begin
      rot_init.x = -x0;
      rot_init.y = -y0;
      rot_init.z = ANGLE_HALF;
    end else begin
      rot_init.x = x0;
      rot_init.y = y0;
      rot_init.z = '0;
    end
  end

  // two rotations per step
  assign rot_mid = rot_step(rot_q, {cmd_i.step, 1'b0});
  assign rot_end = rot_step(rot_mid, {cmd_i.step, 1'b1});

  always_comb begin
    if (cmd_i.init) begin
      rot_d = rot_init;
    end else if (cmd_i.iter) begin
      rot_d = rot_end;
    end else begin
      rot_d = rot_q;
    end
  end

  // run counters walk one sensor per step during the first eight steps
  always_comb begin
    logic [2:0] k;
    logic       cur, prv, m;
    k      = cmd_i.step[2:0];
    cur    = det_q[k];
    prv    = det_q[k - 3'd1];
    m      = mode_q ^ prv;
    mode_d = mode_q;
    run0_d = run0_q;
    run1_d = run1_q;
    if (cmd_i.init) begin
      mode_d = 1'b0;
      run0_d = '0;
      run1_d = '0;
    end else if (cmd_i.iter && !cmd_i.step[3]) begin
      if (cur) begin
        if (prv) begin
          if (cnt_two) begin
            run0_d = 4'd1;
            run1_d = 4'd5;
          end
        end else if (mode_q) begin
          run1_d = run1_q + 1'b1;
        end else begin
          run0_d = run0_q + 1'b1;
        end
      end else begin
        mode_d = m;
        if (m) begin
          run1_d = run1_q + 1'b1;
        end else begin
          run0_d = run0_q + 1'b1;
        end
      end
    end
  end

  // binary angle to degrees with the half-sector offset
  assign deg_raw = 42'(rot_q.z) * 42'd360 + OFFSET_Q32;
  assign deg_mod = (deg_q >= DEG_FULL) ? deg_q - DEG_FULL : deg_q;
  assign run_min = (run0_q > run1_q) ? run1_q : run0_q;

  // result select
  always_comb begin
    dist_d = DIST_BITS'(run_min);
    if (det_q == '0) begin
      dir_d  = DIR_NONE;
      dist_d = DIST_NONE;
    end else if (one_hot) begin
      dir_d  = single_dir(first_k);
      dist_d = '0;
    end else if (zero_sum) begin
      dir_d = prev_q;
    end else if (tie_hit) begin
      dir_d = tie_dir(tie_j);
    end else begin
      dir_d = DIR_BITS'(deg_mod);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      det_q <= det_now;
    end
    rot_q  <= rot_d;
    mode_q <= mode_d;
    run0_q <= run0_d;
    run1_q <= run1_d;
    if (cmd_i.final_calc) begin
      deg_q <= deg_raw[32 +: DEG_BITS];
    end
    if (cmd_i.load) begin
      dir_q  <= dir_d;
      dist_q <= dist_d;
    end
  end

  // last reported direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.load) begin
      prev_q <= dir_d;
    end
  end

  assign dir_o  = dir_q;
  assign dist_o = dist_q;

endmodule

// ===== design/line_ring_direction_estimator.sv =====
// Line direction estimator for a ring of eight sensors 45 degrees apart. Each input beat
// carries one scan; a sensor detects when its sample is at or below the threshold register
// (APB byte address 0, reset 30). Each scan yields exactly one result beat: direction in
// degrees (-1 when nothing detects) and the distance from the two run counters (0 for a
// single sensor, -1 when nothing detects). One scan is in work at a time: from accept to the
// next ready it passes through scan load, start, the 30-rotation CORDIC unit doing two
// rotations per cycle, angle scaling and result load, which waits for a free result slot.
// The result register holds a finished beat while the next scan is taken in.
module line_ring_direction_estimator import lrde_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // scan input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_0 [9:0], sample_1, ..., sample_7 [79:70]
  input  logic [NUM_SENSORS*SAMPLE_BITS-1:0] s_tdata,
  // result output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // direction [9:0], distance [14:10], zero [15]
  output logic [15:0]                        m_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  lrde_cmd_t            cmd;
  logic [THR_BITS-1:0]  thr_q;
  logic [DIR_BITS-1:0]  dir;
  logic [DIST_BITS-1:0] distance;
  logic                 reg_hit;

  // threshold register
  assign reg_hit = (paddr[2] == REG_THRESHOLD);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      thr_q <= pwdata[THR_BITS-1:0];
    end
  end

  assign prdata = reg_hit ? 32'(thr_q) : '0;

  lrde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .cmd_o       (cmd)
  );

  lrde_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .samples_i (s_tdata),
    .thr_i     (thr_q),
    .dir_o     (dir),
    .dist_o    (distance)
  );

  assign m_tdata = {1'b0, distance, dir};

endmodule

// ===== design/lrde_checker.sv =====
`include "assert_macros.svh"

module lrde_checker import lrde_pkg::*; (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [NUM_SENSORS*SAMPLE_BITS-1:0] s_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [15:0]                        m_tdata,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [2:0]                         paddr,
  input logic [31:0]                        pwdata,
  input logic [31:0]                        prdata,
  input logic                               pready
);

  // stalled result beat stays put
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // one scan in work at a time
  `ASSERT_CLK(a_one_scan, s_tvalid && s_tready |=> !s_tready, "scan accepted while another is in work")

  // no-detect distance only comes with no-detect direction
  `ASSERT_CLK(a_none_pair, m_tvalid && (m_tdata[14:10] == 5'h1F) |-> m_tdata[9:0] == 10'h3FF, "distance -1 without direction -1")

  // a real direction is below a full turn
  `ASSERT_CLK(a_dir_range, m_tvalid && (m_tdata[9:0] != 10'h3FF) |-> m_tdata[9:0] < 10'd360, "direction out of range")

  // pad bit of the result is zero
  `ASSERT_CLK(a_pad_zero, m_tvalid |-> !m_tdata[15], "result pad bit set")

endmodule

bind line_ring_direction_estimator lrde_checker u_lrde_checker (.*);

// ===== tb/line_ring_direction_estimator_test.sv =====
`timescale 1ns / 1ps

module line_ring_direction_estimator_test;
  import lrde_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [NUM_SENSORS-1:0] scan_t;
  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [DIR_BITS-1:0]  direction;
  } line_fix_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [2:0] THRESHOLD_ADDR = 3'(4 * REG_THRESHOLD);

  // q32 constants for the vector sum and the angle scaling
  localparam longint UNIT_Q32      = 64'sd4294967296;
  localparam longint ROOT_HALF_Q32 = 64'sd3037000500;
  localparam logic [63:0] SPIN_OFFSET = 64'd96636764160;

  // arctangent of 2^-i, a full turn is 2^32
  localparam logic [31:0] ATAN_STEP [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // direction vectors at 22.5 + 45*j degrees: x = a + b*r, y = c + d*r, r = sqrt(2)/2
  localparam int SPLIT_DIR [8][4] = '{
    '{ 1,  0, -1,  2}, '{-1,  2,  1,  0}, '{ 1, -2,  1,  0}, '{-1,  0, -1,  2},
    '{-1,  0,  1, -2}, '{ 1, -2, -1,  0}, '{-1,  2, -1,  0}, '{ 1,  0,  1, -2}
  };

  logic                               clk_i    = 1'b0;
  logic                               rst_ni   = 1'b0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  // sample_0 [9:0], sample_1 [19:10], ..., sample_7 [79:70]
  logic [NUM_SENSORS*SAMPLE_BITS-1:0] s_tdata  = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  // direction [9:0], distance [14:10], zero [15]
  logic [15:0]                        m_tdata;
  logic                               psel     = 1'b0;
  logic                               penable  = 1'b0;
  logic                               pwrite   = 1'b0;
  logic [2:0]                         paddr    = '0;
  logic [31:0]                        pwdata   = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  // model state
  logic [THR_BITS-1:0] cfg_threshold = THR_RESET;
  logic [DIR_BITS-1:0] last_heading  = '0;

  scan_t       scan_q [$];
  line_fix_t   predicted_lines [$];
  scan_t       cur_scan;
  line_fix_t   want_fix;
  int          scan_pause, line_stall;
  int unsigned scans_queued, scans_sent, lines_seen, mismatches, cycle_count;
  int unsigned blank_seen, single_seen, multi_seen, balanced_seen, tie_seen, settings_used;

  line_ring_direction_estimator i_dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // twice the product (a + b*r)(c + d*r), as p + q*r
  function automatic void mul_root2(input longint a, b, c, d, output longint p, q);
    p = 2 * a * c + b * d;
    q = 2 * (a * d + b * c);
  endfunction

  // direction and distance for one scan, updates the held direction
  function automatic line_fix_t estimate_line(input scan_t scan);
    logic [7:0]  hit;
    int          n [8];
    int          i, j, cnt, first, mode, tie;
    int          run [2];
    longint      xa, xb, ya, yb, p1, q1, p2, q2, p, q, cx, cy, dx, dy;
    logic [31:0] ang;
    logic [63:0] scaled;
    logic        pos, prev;
    line_fix_t   fix;
    cnt = 0;
    first = 0;
    mode = 0;
    tie = -1;
    run[0] = 0;
    run[1] = 0;
    for (i = 0; i < 8; i++) begin
      hit[i] = scan[i] <= cfg_threshold;
      n[i] = hit[i] ? 1 : 0;
      if (hit[i] && cnt == 0) first = i;
      if (hit[i]) cnt++;
    end
    if (cnt == 0) begin
      fix.direction = '1;
      fix.distance = '1;
      blank_seen++;
    end else if (cnt == 1) begin
      fix.direction = 10'((45 * first + 46) % 360);
      fix.distance = '0;
      single_seen++;
    end else begin
      xa = n[0] - n[4];
      xb = n[1] - n[3] - n[5] + n[7];
      ya = n[2] - n[6];
      yb = n[1] + n[3] - n[5] - n[7];
      if (xa == 0 && xb == 0 && ya == 0 && yb == 0) begin
        // opposite sensors cancel, keep what was reported last
        fix.direction = last_heading;
        balanced_seen++;
      end else begin
        // exact half-way directions between two sensors
        for (j = 0; j < 8 && tie < 0; j++) begin
          mul_root2(xa, xb, SPLIT_DIR[j][2], SPLIT_DIR[j][3], p1, q1);
          mul_root2(ya, yb, SPLIT_DIR[j][0], SPLIT_DIR[j][1], p2, q2);
          if (p1 == p2 && q1 == q2) begin
            mul_root2(xa, xb, SPLIT_DIR[j][0], SPLIT_DIR[j][1], p1, q1);
            mul_root2(ya, yb, SPLIT_DIR[j][2], SPLIT_DIR[j][3], p2, q2);
            p = p1 + p2;
            q = q1 + q2;
            if (p >= 0 && q >= 0) pos = (p != 0 || q != 0);
            else if (p <= 0 && q <= 0) pos = 1'b0;
            else if (p > 0) pos = (2 * p * p > q * q);
            else pos = (q * q > 2 * p * p);
            if (pos) tie = j;
          end
        end
        if (tie >= 0) begin
          fix.direction = 10'((45 * (tie + 1)) % 360);
          tie_seen++;
        end else begin
          // vectoring cordic on the q32 sum
          cx = xa * UNIT_Q32 + xb * ROOT_HALF_Q32;
          cy = ya * UNIT_Q32 + yb * ROOT_HALF_Q32;
          ang = '0;
          if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            ang = 32'h8000_0000;
          end
          for (i = 0; i < 30; i++) begin
            dx = cx / (longint'(1) << i);
            dy = cy / (longint'(1) << i);
            if (cy > 0) begin
              cx += dy;
              cy -= dx;
              ang += ATAN_STEP[i];
            end else begin
              cx -= dy;
              cy += dx;
              ang -= ATAN_STEP[i];
            end
          end
          scaled = {32'd0, ang} * 64'd360 + SPIN_OFFSET;
          fix.direction = 10'(scaled[63:32] % 360);
        end
      end
      // run counters switch at each detect-to-clear step around the ring
      for (i = 0; i < 8; i++) begin
        prev = hit[(i + 7) % 8];
        if (hit[i]) begin
          if (prev) begin
            if (cnt == 2) begin
              run[0] = 1;
              run[1] = 5;
            end
          end else begin
            run[mode]++;
          end
        end else begin
          if (prev) mode ^= 1;
          run[mode]++;
        end
      end
      fix.distance = 5'(run[0] > run[1] ? run[1] : run[0]);
      multi_seen++;
    end
    last_heading = fix.direction;
    return fix;
  endfunction

  // idle length per beat, with runs of back-to-back beats
  function automatic int draw_pause(input int unsigned beat_no);
    return ((beat_no / 32) % 3 == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  // fixed samples: on_val for sensors in the mask, off_val elsewhere
  function automatic scan_t flat(input logic [7:0] mask, input sample_t on_val, off_val);
    scan_t s;
    for (int i = 0; i < 8; i++) s[i] = mask[i] ? on_val : off_val;
    return s;
  endfunction

  // random scan, mostly built from a detection pattern around the threshold
  function automatic scan_t shaped_scan(input logic [THR_BITS-1:0] level);
    scan_t      s;
    logic [7:0] mask, base;
    logic [15:0] spun;
    int         pick, len;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      for (int i = 0; i < 8; i++) s[i] = sample_t'($urandom_range(0, 1023));
      return s;
    end
    if (pick == 2) begin
      mask = 8'($urandom_range(0, 255));
    end else if (pick <= 6) begin
      // one arc, or two arcs for pick 6
      len = $urandom_range(1, 8);
      base = 8'((1 << len) - 1);
      spun = {base, base} << $urandom_range(0, 7);
      mask = spun[15:8];
      if (pick == 6) begin
        len = $urandom_range(1, 3);
        base = 8'((1 << len) - 1);
        spun = {base, base} << $urandom_range(0, 7);
        mask |= spun[15:8];
      end
    end else if (pick == 7) begin
      // pairs of opposite sensors only
      mask[3:0] = 4'($urandom_range(1, 15));
      mask[7:4] = mask[3:0];
    end else if (pick == 8) begin
      mask = 8'(1 << $urandom_range(0, 7));
    end else begin
      mask = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      if (mask[i] || level == '1)
        s[i] = ($urandom_range(0, 3) == 0) ? level : sample_t'($urandom_range(0, level));
      else
        s[i] = ($urandom_range(0, 3) == 0) ? sample_t'(level + 1)
                                           : sample_t'($urandom_range(level + 1, 1023));
    end
    return s;
  endfunction

  task automatic queue_scan(input scan_t s);
    scan_q.push_back(s);
    scans_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (scans_sent != scans_queued || predicted_lines.size() != 0);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_threshold(input logic [THR_BITS-1:0] level);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= 32'(level);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_threshold = level;
    settings_used++;
  endtask

  task automatic run_phase(input logic [THR_BITS-1:0] level, input int count);
    write_threshold(level);
    repeat (count) queue_scan(shaped_scan(level));
    wait_drained();
  endtask

  // scan driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      scan_pause = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predicted_lines.push_back(estimate_line(cur_scan));
        scans_sent++;
        scan_pause = draw_pause(scans_sent);
      end
      if (scan_pause != 0) begin
        scan_pause--;
        s_tvalid <= 1'b0;
      end else if (scan_q.size() != 0) begin
        cur_scan = scan_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_scan;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      line_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_lines.size() == 0) begin
          $error("result beat %h with no scan pending", m_tdata);
          mismatches++;
        end else begin
          want_fix = predicted_lines.pop_front();
          if (m_tdata[9:0] !== want_fix.direction) begin
            $error("direction: expected %0d, got %0d",
                   $signed(want_fix.direction), $signed(m_tdata[9:0]));
            mismatches++;
          end
          if (m_tdata[14:10] !== want_fix.distance) begin
            $error("distance: expected %0d, got %0d",
                   $signed(want_fix.distance), $signed(m_tdata[14:10]));
            mismatches++;
          end
          if (m_tdata[15] !== 1'b0) begin
            $error("zero pad bit: expected 0, got %b", m_tdata[15]);
            mismatches++;
          end
        end
        lines_seen++;
        line_stall = draw_pause(lines_seen);
      end else if (m_tvalid && line_stall != 0) begin
        line_stall--;
      end
      m_tready <= (line_stall == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, predicted_lines.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed scans at the reset threshold
    queue_scan(flat(8'hFF, 10'd0, 10'd0));
    queue_scan(flat(8'h00, 10'd1023, 10'd1023));
    queue_scan(flat(8'hFF, 10'd30, 10'd30));
    queue_scan(flat(8'h00, 10'd31, 10'd31));
    for (int k = 0; k < 8; k++) queue_scan(flat(8'(1 << k), 10'd30, 10'd31));
    queue_scan(flat(8'h03, 10'd0, 10'd1023));
    queue_scan(flat(8'h81, 10'd0, 10'd1023));
    queue_scan(flat(8'h07, 10'd5, 10'd700));
    queue_scan(flat(8'h11, 10'd12, 10'd500));
    queue_scan(flat(8'h25, 10'd1, 10'd64));
    queue_scan(flat(8'h55, 10'd29, 10'd1023));
    queue_scan(flat(8'hAA, 10'h155, 10'h2AA));
    queue_scan(flat(8'h55, 10'h155, 10'h2AA));
    wait_drained();

    // random phases over several thresholds, extremes first
    run_phase(10'd1023, 40);
    run_phase(10'd0, 40);
    run_phase(10'd30, 100);
    run_phase(THR_BITS'($urandom_range(1, 1022)), 100);
    run_phase(10'd512, 100);
    run_phase(THR_BITS'($urandom_range(1, 1022)), 100);

    repeat (40) @(posedge clk_i);
    $display("%0d scans checked across %0d threshold settings, %0d mismatches",
             lines_seen, settings_used, mismatches);
    $display("%0d blank, %0d single-sensor, %0d multi-sensor (%0d cancelled, %0d half-way)",
             blank_seen, single_seen, multi_seen, balanced_seen, tie_seen);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
